@@ rtl/bde_pkg.sv @@
// Shared types and constants for the edge-directed Bayer demosaic block.
// Used by every module under rtl; depends on nothing else.
package bde_pkg;

  // Sample width and default store limits.
  localparam int SAMPLE_W       = 8;
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int DEF_QUEUE_DEPTH = 4;

  // Configuration port.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 9;
  localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BORDER_VALUE  = 2'd2;

  // Register reset values and the smallest frame dimension.
  localparam int RESET_ACTIVE_WIDTH  = 176;
  localparam int RESET_ACTIVE_HEIGHT = 144;
  localparam logic [SAMPLE_W-1:0] RESET_BORDER_VALUE = 8'h80;
  localparam int DIM_MIN = 2;

  // Bayer phase of a GRBG site: {row parity, column parity}.
  localparam logic [1:0] PHASE_GREEN_R = 2'd0;
  localparam logic [1:0] PHASE_RED     = 2'd1;
  localparam logic [1:0] PHASE_BLUE    = 2'd2;
  localparam logic [1:0] PHASE_GREEN_B = 2'd3;

  // One raw request.
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                pad;
  } pixel_in_t;

  // One finished RGB pixel.
  typedef struct packed {
    logic [SAMPLE_W-1:0] red;
    logic [SAMPLE_W-1:0] green;
    logic [SAMPLE_W-1:0] blue;
    logic                frame_end;
  } pixel_out_t;

  // Classification of the pixel that leaves the window centre.
  typedef struct packed {
    logic       emit;
    logic [1:0] phase;
    logic       edge_left;
    logic       edge_right;
    logic       edge_up;
    logic       edge_down;
    logic       last;
  } ctrl_t;

  // One new window column (rows y-2, y-1, y) and the pixel classification.
  typedef struct packed {
    logic [SAMPLE_W-1:0] top;
    logic [SAMPLE_W-1:0] mid;
    logic [SAMPLE_W-1:0] bot;
    ctrl_t               ctrl;
  } column_t;

endpackage

@@ rtl/bayer_demosaic_edge_directed.sv @@
// Top level of the edge-directed GRBG demosaic: configuration registers and
// the front end, queue and back end. Depends on bde_pkg and the bde_ modules.
//
//   channel  direction  handshake              payload
//   pix      in         pix_valid / pix_ready  pixel_in_t  {sample, pad}
//   rgb      out        rgb_valid / rgb_ready  pixel_out_t {red, green, blue, frame_end}
//   cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// While the output does not stall, one sample is taken per cycle and every stage
// passes one item per cycle; the line store has one read and one write port.
// A pixel passes the holding, queue, window and output registers after the
// sample completing it, one row and one column after its own; each frame needs
// active_width+1 pad items. Synchronous reset clears control state only; the
// line store needs no clearing pass, so samples are taken from the first cycle
// after reset. A stalled output fills the queue, after which pix_ready drops.
module bayer_demosaic_edge_directed import bde_pkg::*; #(
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT  = DEF_MAX_HEIGHT,
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   pix_valid,
  output logic                   pix_ready,
  input  pixel_in_t              pix,
  output logic                   rgb_valid,
  input  logic                   rgb_ready,
  output pixel_out_t             rgb,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RST_W = (RESET_ACTIVE_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_ACTIVE_WIDTH;
  localparam int RST_H = (RESET_ACTIVE_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RESET_ACTIVE_HEIGHT;

  logic [WW-1:0]       active_width;
  logic [HW-1:0]       active_height;
  logic [SAMPLE_W-1:0] border_value;
  logic [WW-1:0]       width_clamped;
  logic [HW-1:0]       height_clamped;
  logic                restart;
  logic                fq_valid;
  logic                fq_ready;
  column_t             fq_data;
  logic                qb_valid;
  logic                qb_ready;
  column_t             qb_data;

  assign cfg_ready = 1'b1;
  assign restart   = cfg_valid &&
                     (cfg_index == REG_ACTIVE_WIDTH || cfg_index == REG_ACTIVE_HEIGHT);

  // Frame dimensions are clamped to the supported range when written.
  always_comb begin
    if (cfg_data < CFG_DATA_W'(DIM_MIN)) begin
      width_clamped = WW'(DIM_MIN);
    end else if (int'(cfg_data) > MAX_WIDTH) begin
      width_clamped = WW'(MAX_WIDTH);
    end else begin
      width_clamped = WW'(cfg_data);
    end
    if (cfg_data < CFG_DATA_W'(DIM_MIN)) begin
      height_clamped = HW'(DIM_MIN);
    end else if (int'(cfg_data) > MAX_HEIGHT) begin
      height_clamped = HW'(MAX_HEIGHT);
    end else begin
      height_clamped = HW'(cfg_data);
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      active_width  <= WW'(RST_W);
      active_height <= HW'(RST_H);
      border_value  <= RESET_BORDER_VALUE;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ACTIVE_WIDTH:  active_width  <= width_clamped;
        REG_ACTIVE_HEIGHT: active_height <= height_clamped;
        REG_BORDER_VALUE:  border_value  <= cfg_data[SAMPLE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  bde_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .pix_valid     (pix_valid),
    .pix_ready     (pix_ready),
    .pix           (pix),
    .active_width  (active_width),
    .active_height (active_height),
    .border_value  (border_value),
    .restart       (restart),
    .column_valid  (fq_valid),
    .column_ready  (fq_ready),
    .column        (fq_data)
  );

  bde_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_data),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_data)
  );

  bde_back u_back (
    .clk          (clk),
    .rst          (rst),
    .column_valid (qb_valid),
    .column_ready (qb_ready),
    .column       (qb_data),
    .border_value (border_value),
    .rgb_valid    (rgb_valid),
    .rgb_ready    (rgb_ready),
    .rgb          (rgb)
  );

endmodule

@@ rtl/bde_front.sv @@
// Front end: accepts raw samples, tracks raster position, runs the line store
// and classifies the pixel to be produced. Depends on bde_pkg.
module bde_front import bde_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  localparam int AW = $clog2(MAX_WIDTH),
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int HW = $clog2(MAX_HEIGHT + 1),
  localparam int RW = $clog2(MAX_HEIGHT + 2)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                pix_valid,
  output logic                pix_ready,
  input  pixel_in_t           pix,
  input  logic [WW-1:0]       active_width,
  input  logic [HW-1:0]       active_height,
  input  logic [SAMPLE_W-1:0] border_value,
  input  logic                restart,
  output logic                column_valid,
  input  logic                column_ready,
  output column_t             column
);

  logic [AW-1:0]         col_count;
  logic [RW-1:0]         row_count;
  logic [WW-1:0]         ix;
  logic [WW-1:0]         col_inc;
  logic [WW-1:0]         ox;
  logic [RW-1:0]         h_ext;
  logic [RW-1:0]         oy;
  logic                  x_zero;
  logic                  wrap;
  logic                  in_tail;
  logic                  past_end;
  logic [SAMPLE_W-1:0]   s;
  ctrl_t                 ctrl_new;
  logic                  accept;
  logic                  push;

  logic                  f1_valid;
  logic [AW-1:0]         f1_addr;
  logic [SAMPLE_W-1:0]   f1_sample;
  ctrl_t                 f1_ctrl;

  logic [2*SAMPLE_W-1:0] line_mem [MAX_WIDTH];
  logic [2*SAMPLE_W-1:0] rd_q;
  logic [2*SAMPLE_W-1:0] byp_data;
  logic                  byp_hit;
  logic [2*SAMPLE_W-1:0] line;
  logic [2*SAMPLE_W-1:0] wr_line;

  assign accept    = pix_valid && pix_ready;
  assign push      = f1_valid && column_ready;
  assign pix_ready = !f1_valid || column_ready;

  // Position of the incoming sample and of the pixel it completes.
  always_comb begin
    ix       = WW'(col_count);
    col_inc  = ix + WW'(1);
    wrap     = col_inc >= active_width;
    h_ext    = RW'(active_height);
    in_tail  = row_count >= h_ext;
    past_end = row_count >= h_ext + RW'(1);
    x_zero   = col_count == '0;
    s        = (in_tail || pix.pad) ? border_value : pix.sample;
    if (x_zero) begin
      ox            = active_width - WW'(1);
      oy            = row_count - RW'(2);
      ctrl_new.emit = (row_count >= RW'(2)) && (row_count <= h_ext + RW'(1));
    end else begin
      ox            = ix - WW'(1);
      oy            = row_count - RW'(1);
      ctrl_new.emit = (row_count >= RW'(1)) && (row_count <= h_ext);
    end
    ctrl_new.phase      = {oy[0], ox[0]};
    ctrl_new.edge_left  = ox == '0;
    ctrl_new.edge_right = ox == active_width - WW'(1);
    ctrl_new.edge_up    = oy == '0;
    ctrl_new.edge_down  = oy == h_ext - RW'(1);
    ctrl_new.last       = ctrl_new.edge_right && ctrl_new.edge_down;
  end

  // Raster counters; the flush tail returns them to the frame origin.
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (past_end) begin
        col_count <= '0;
        row_count <= '0;
      end else if (wrap) begin
        col_count <= '0;
        row_count <= row_count + RW'(1);
      end else begin
        col_count <= AW'(col_inc);
      end
    end
  end

  // Holding stage while the line store read completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (pix_ready) begin
      f1_valid <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_addr   <= col_count;
      f1_sample <= s;
      f1_ctrl   <= ctrl_new;
    end
  end

  // Line store: each entry holds {two rows up, one row up} for its column.
  // It is read when a sample is accepted and rewritten when the sample moves
  // on; a write to the address being read is forwarded.
  assign line    = byp_hit ? byp_data : rd_q;
  assign wr_line = {line[SAMPLE_W-1:0], f1_sample};

  always_ff @(posedge clk) begin
    if (push) begin
      line_mem[f1_addr] <= wr_line;
    end
    if (accept) begin
      rd_q     <= line_mem[col_count];
      byp_hit  <= push && (f1_addr == col_count);
      byp_data <= wr_line;
    end
  end

  // New window column towards the back end.
  assign column_valid = f1_valid;
  assign column.top   = line[2*SAMPLE_W-1:SAMPLE_W];
  assign column.mid   = line[SAMPLE_W-1:0];
  assign column.bot   = f1_sample;
  assign column.ctrl  = f1_ctrl;

  // The column counter stays inside the active row.
  assert property (@(posedge clk) disable iff (rst) ix < active_width)
    else $error("column counter outside the active width");

  // The row counter never passes the flush row.
  assert property (@(posedge clk) disable iff (rst) row_count <= h_ext + RW'(1))
    else $error("row counter beyond the flush row");

endmodule

@@ rtl/bde_queue.sv @@
// Short queue of window columns between the front and back ends.
// Depends on bde_pkg.
module bde_queue import bde_pkg::*; #(
  parameter int DEPTH = DEF_QUEUE_DEPTH,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push_valid,
  output logic    push_ready,
  input  column_t push_data,
  output logic    pop_valid,
  input  logic    pop_ready,
  output column_t pop_data
);

  column_t       entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  assign push_ready = count != CW'(DEPTH);
  assign pop_valid  = count != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = entries[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("queue fill level beyond its depth");

  assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + CW'(1)))
    else $error("queue fill level did not rise on a lone write");

endmodule

@@ rtl/bde_back.sv @@
// Back end: shifts columns into the 3x3 window and interpolates the missing
// colours of the centre pixel into the output register. Depends on bde_pkg.
module bde_back import bde_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                column_valid,
  output logic                column_ready,
  input  column_t             column,
  input  logic [SAMPLE_W-1:0] border_value,
  output logic                rgb_valid,
  input  logic                rgb_ready,
  output pixel_out_t          rgb
);

  logic [SAMPLE_W-1:0] win [9];
  logic                a_valid;
  ctrl_t               a_ctrl;
  logic                out_free;
  logic                a_done;
  logic                pop;
  logic [SAMPLE_W-1:0] c, l, r, u, d, ul, ur, dl, dr;
  logic [SAMPLE_W-1:0] mean_lr, mean_ud, edge_cross, edge_diag;
  pixel_out_t          result;

  // Truncated mean of two samples.
  function automatic logic [SAMPLE_W-1:0] pair_mean(input logic [SAMPLE_W-1:0] a,
                                                     input logic [SAMPLE_W-1:0] b);
    logic [SAMPLE_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[SAMPLE_W:1];
  endfunction

  // Mean of the pair with the smaller spread, or of all four on a tie.
  function automatic logic [SAMPLE_W-1:0] edge_mean(input logic [SAMPLE_W-1:0] a1,
                                                     input logic [SAMPLE_W-1:0] a2,
                                                     input logic [SAMPLE_W-1:0] b1,
                                                     input logic [SAMPLE_W-1:0] b2);
    logic [SAMPLE_W-1:0] da;
    logic [SAMPLE_W-1:0] db;
    logic [SAMPLE_W:0]   sa;
    logic [SAMPLE_W:0]   sb;
    logic [SAMPLE_W+1:0] s4;
    da = (a1 > a2) ? a1 - a2 : a2 - a1;
    db = (b1 > b2) ? b1 - b2 : b2 - b1;
    sa = {1'b0, a1} + {1'b0, a2};
    sb = {1'b0, b1} + {1'b0, b2};
    s4 = {1'b0, sa} + {1'b0, sb};
    if (da < db) begin
      return sa[SAMPLE_W:1];
    end else if (db < da) begin
      return sb[SAMPLE_W:1];
    end else begin
      return s4[SAMPLE_W+1:2];
    end
  endfunction

  assign out_free     = !rgb_valid || rgb_ready;
  assign a_done       = a_valid && (!a_ctrl.emit || out_free);
  assign column_ready = !a_valid || a_done;
  assign pop          = column_valid && column_ready;

  // Window shift: one new column per item, emitted or not.
  always_ff @(posedge clk) begin
    if (pop) begin
      win[0] <= win[1];
      win[1] <= win[2];
      win[2] <= column.top;
      win[3] <= win[4];
      win[4] <= win[5];
      win[5] <= column.mid;
      win[6] <= win[7];
      win[7] <= win[8];
      win[8] <= column.bot;
      a_ctrl <= column.ctrl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (pop) begin
      a_valid <= 1'b1;
    end else if (a_done) begin
      a_valid <= 1'b0;
    end
  end

  // Neighbours, with border_value outside the frame.
  always_comb begin
    c  = win[4];
    l  = a_ctrl.edge_left  ? border_value : win[3];
    r  = a_ctrl.edge_right ? border_value : win[5];
    u  = a_ctrl.edge_up    ? border_value : win[1];
    d  = a_ctrl.edge_down  ? border_value : win[7];
    ul = (a_ctrl.edge_left  || a_ctrl.edge_up)   ? border_value : win[0];
    ur = (a_ctrl.edge_right || a_ctrl.edge_up)   ? border_value : win[2];
    dl = (a_ctrl.edge_left  || a_ctrl.edge_down) ? border_value : win[6];
    dr = (a_ctrl.edge_right || a_ctrl.edge_down) ? border_value : win[8];
  end

  // Interpolation by Bayer phase.
  always_comb begin
    mean_lr    = pair_mean(l, r);
    mean_ud    = pair_mean(u, d);
    edge_cross = edge_mean(l, r, u, d);
    edge_diag  = edge_mean(ul, ur, dl, dr);
    result.frame_end = a_ctrl.last;
    case (a_ctrl.phase)
      PHASE_GREEN_R: begin
        result.red   = mean_lr;
        result.green = c;
        result.blue  = mean_ud;
      end
      PHASE_RED: begin
        result.red   = c;
        result.green = edge_cross;
        result.blue  = edge_diag;
      end
      PHASE_BLUE: begin
        result.red   = edge_diag;
        result.green = edge_cross;
        result.blue  = c;
      end
      default: begin
        result.red   = mean_ud;
        result.green = c;
        result.blue  = mean_lr;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rgb_valid <= 1'b0;
    end else if (a_valid && a_ctrl.emit && out_free) begin
      rgb_valid <= 1'b1;
    end else if (rgb_ready) begin
      rgb_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid && a_ctrl.emit && out_free) begin
      rgb <= result;
    end
  end

endmodule

@@ sim/tb_bayer_demosaic_edge_directed.sv @@
// Self-checking testbench for the edge-directed GRBG demosaic block.
// Depends on bde_pkg and bayer_demosaic_edge_directed from the rtl folder.
module tb_bayer_demosaic_edge_directed;
  import bde_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Register index with no register behind it; writes to it are ignored.
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1150;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_LIMIT   = 4000;

  // Predicts every RGB pixel from the accepted raw requests and checks the
  // pixels that leave the block against those predictions in order.
  class demosaic_scoreboard;
    int unsigned width_q;
    int unsigned height_q;
    bit [7:0]    border_q;
    bit [7:0]    above_row [DEF_MAX_WIDTH];
    bit [7:0]    cur_row   [DEF_MAX_WIDTH];
    bit [7:0]    win [9];
    int unsigned col_q;
    int unsigned row_q;
    pixel_out_t  expected_q [$];
    int          mismatches;
    int          checked;

    function new();
      width_q    = RESET_ACTIVE_WIDTH;
      height_q   = RESET_ACTIVE_HEIGHT;
      border_q   = RESET_BORDER_VALUE;
      col_q      = 0;
      row_q      = 0;
      mismatches = 0;
      checked    = 0;
      foreach (win[i]) win[i] = '0;
      foreach (above_row[i]) begin
        above_row[i] = '0;
        cur_row[i]   = '0;
      end
    endfunction

    function int unsigned clamp_dim(bit [8:0] v, int unsigned limit);
      if (v < DIM_MIN) return DIM_MIN;
      if (v > limit) return limit;
      return v;
    endfunction

    // Register write; a new width or height restarts the frame.
    function void write_reg(bit [CFG_INDEX_W-1:0] idx, bit [CFG_DATA_W-1:0] data);
      case (idx)
        REG_ACTIVE_WIDTH: begin
          width_q = clamp_dim(data, DEF_MAX_WIDTH);
          col_q   = 0;
          row_q   = 0;
        end
        REG_ACTIVE_HEIGHT: begin
          height_q = clamp_dim(data, DEF_MAX_HEIGHT);
          col_q    = 0;
          row_q    = 0;
        end
        REG_BORDER_VALUE: border_q = data[7:0];
        default: ;
      endcase
    endfunction

    function bit [7:0] avg2(bit [7:0] a, bit [7:0] b);
      return 8'((int'(a) + int'(b)) / 2);
    endfunction

    // Mean of the flatter pair, or of all four when both pairs differ equally.
    function bit [7:0] edge_mean(bit [7:0] a1, bit [7:0] a2, bit [7:0] b1, bit [7:0] b2);
      int da;
      int db;
      da = (a1 > a2) ? a1 - a2 : a2 - a1;
      db = (b1 > b2) ? b1 - b2 : b2 - b1;
      if (da < db) return avg2(a1, a2);
      if (db < da) return avg2(b1, b2);
      return 8'((int'(a1) + int'(a2) + int'(b1) + int'(b2)) / 4);
    endfunction

    // Neighbour of pixel (ox,oy); anything outside the frame reads the border.
    function bit [7:0] neighbour(int ox, int oy, int dc, int dr);
      int nx;
      int ny;
      nx = ox + dc;
      ny = oy + dr;
      if (nx < 0 || ny < 0 || nx >= int'(width_q) || ny >= int'(height_q))
        return border_q;
      return win[(dr + 1) * 3 + (dc + 1)];
    endfunction

    // Advances the stores for one accepted request and queues the pixel it completes.
    function void note_pixel(pixel_in_t it);
      int         ix;
      int         iy;
      int         w;
      int         h;
      int         ox;
      int         oy;
      int         col;
      bit [7:0]   s;
      bit [7:0]   top;
      bit [7:0]   mid;
      bit [7:0]   c;
      bit [7:0]   nl;
      bit [7:0]   nr;
      bit [7:0]   nu;
      bit [7:0]   nd;
      bit [1:0]   phase;
      bit         emit;
      pixel_out_t want;
      ix = col_q;
      iy = row_q;
      w  = width_q;
      h  = height_q;
      s  = (iy >= h || it.pad) ? border_q : it.sample;
      col = (ix < DEF_MAX_WIDTH) ? ix : DEF_MAX_WIDTH - 1;
      top = above_row[col];
      mid = cur_row[col];
      above_row[col] = mid;
      cur_row[col]   = s;
      for (int r = 0; r < 3; r++) begin
        win[r * 3]     = win[r * 3 + 1];
        win[r * 3 + 1] = win[r * 3 + 2];
      end
      win[2] = top;
      win[5] = mid;
      win[8] = s;
      if (ix >= 1) begin
        ox   = ix - 1;
        oy   = iy - 1;
        emit = (iy >= 1) && (iy <= h);
      end else begin
        ox   = w - 1;
        oy   = iy - 2;
        emit = (iy >= 2) && (iy <= h + 1);
      end
      col_q = ix + 1;
      if (col_q >= w) begin
        col_q = 0;
        row_q = iy + 1;
      end
      if (iy >= h + 1) begin
        col_q = 0;
        row_q = 0;
      end
      if (!emit) return;

      c  = win[4];
      nl = neighbour(ox, oy, -1, 0);
      nr = neighbour(ox, oy, 1, 0);
      nu = neighbour(ox, oy, 0, -1);
      nd = neighbour(ox, oy, 0, 1);
      phase = {oy[0], ox[0]};
      case (phase)
        PHASE_GREEN_R: begin
          want.green = c;
          want.red   = avg2(nl, nr);
          want.blue  = avg2(nu, nd);
        end
        PHASE_RED: begin
          want.red   = c;
          want.green = edge_mean(nl, nr, nu, nd);
          want.blue  = edge_mean(neighbour(ox, oy, -1, -1), neighbour(ox, oy, 1, -1),
                                 neighbour(ox, oy, -1, 1), neighbour(ox, oy, 1, 1));
        end
        PHASE_BLUE: begin
          want.blue  = c;
          want.green = edge_mean(nl, nr, nu, nd);
          want.red   = edge_mean(neighbour(ox, oy, -1, -1), neighbour(ox, oy, 1, -1),
                                 neighbour(ox, oy, -1, 1), neighbour(ox, oy, 1, 1));
        end
        default: begin
          want.green = c;
          want.blue  = avg2(nl, nr);
          want.red   = avg2(nu, nd);
        end
      endcase
      want.frame_end = (ox == w - 1) && (oy == h - 1);
      expected_q.push_back(want);
    endfunction

    // Compares one delivered pixel with the oldest prediction.
    function void check_rgb(pixel_out_t got);
      pixel_out_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: pixel with none predicted: r=%h g=%h b=%h end=%b",
                   $realtime, got.red, got.green, got.blue, got.frame_end);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
          got.frame_end !== want.frame_end) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: pixel %0d expected r=%h g=%h b=%h end=%b, got r=%h g=%h b=%h end=%b",
                   $realtime, checked, want.red, want.green, want.blue, want.frame_end,
                   got.red, got.green, got.blue, got.frame_end);
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   pix_valid;
  logic                   pix_ready;
  pixel_in_t              pix;
  logic                   rgb_valid;
  logic                   rgb_ready;
  pixel_out_t             rgb;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  demosaic_scoreboard sb;
  int  pixels_sent;
  int  directed_items;
  int  frames_sent;
  int  settings_used;
  int  phase_no;
  bit  burst;
  bit  hold_request;

  bayer_demosaic_edge_directed u_dut (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix       (pix),
    .rgb_valid (rgb_valid),
    .rgb_ready (rgb_ready),
    .rgb       (rgb),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clock with a 2 ns period.
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Gap length: mostly none or short, now and then long; none in a burst.
  function automatic int pick_gap();
    int roll;
    if (burst) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Raw sample biased towards the extremes and the border so that ties occur.
  function automatic logic [7:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      2: return sb.border_q;
      default: return 8'($urandom);
    endcase
  endfunction

  // Offers one raw request and waits until the block takes it.
  task automatic send_pixel(input logic [7:0] smp, input logic pd);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      pix_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix       <= pixel_in_t'{sample: smp, pad: pd};
    pix_valid <= 1'b1;
    do @(posedge clk); while (!pix_ready);
    sb.note_pixel(pix);
    pixels_sent++;
    @(negedge clk);
  endtask

  // One register write; the caller lowers cfg_valid after the last one.
  task automatic program_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
  endtask

  // Stops offering and waits until every predicted pixel has come out.
  task automatic settle();
    pix_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Reprograms all registers once the block is idle.
  task automatic set_frame(input logic [8:0] w_raw, input logic [8:0] h_raw,
                           input logic [7:0] border, input bit touch_unused);
    settle();
    program_reg(REG_ACTIVE_WIDTH, w_raw);
    program_reg(REG_ACTIVE_HEIGHT, h_raw);
    program_reg(REG_BORDER_VALUE, {1'($urandom_range(0, 1)), border});
    if (touch_unused) program_reg(REG_UNUSED, 9'($urandom));
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // One frame of random samples and its flush; a cut frame stops part way.
  task automatic send_frame(input bit cut);
    int w;
    int h;
    int stop;
    w = sb.width_q;
    h = sb.height_q;
    stop = cut ? $urandom_range(1, w * h - 1) : w * h;
    for (int n = 0; n < stop; n++) begin
      if ($urandom_range(0, 99) < 4) send_pixel(8'($urandom), 1'b1);
      else send_pixel(pick_sample(), 1'b0);
    end
    if (!cut) begin
      for (int n = 0; n <= w; n++)
        send_pixel(8'($urandom), ($urandom_range(0, 99) < 15) ? 1'b0 : 1'b1);
      frames_sent++;
    end
  endtask

  function automatic logic [7:0] pick_border();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Receiver: random gaps, plus one long hold-off when the sender asks.
  initial begin : receiver
    int gap_left;
    int hold_left;
    gap_left  = 0;
    hold_left = 0;
    rgb_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        rgb_ready <= 1'b0;
        hold_left--;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES - 1;
        rgb_ready   <= 1'b0;
      end else if (gap_left > 0) begin
        rgb_ready <= 1'b0;
        gap_left--;
      end else begin
        rgb_ready <= 1'b1;
        if (!burst && $urandom_range(0, 99) < 30) gap_left = pick_gap();
      end
    end
  end

  // Every delivered pixel is checked at the edge that accepts it.
  always @(posedge clk) begin
    if (!rst && rgb_valid && rgb_ready) sb.check_rgb(rgb);
  end

  // Watchdog: too long without any request accepted on any channel.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((pix_valid && pix_ready) || (rgb_valid && rgb_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) break;
    end
    $display("Timeout after %0d idle cycles", IDLE_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  // Main sequence: reset, directed frames, then random settings and frames.
  initial begin : stimulus
    int nfr;
    int roll;
    logic [8:0] w_raw;
    logic [8:0] h_raw;
    sb = new();
    rst          = 1'b1;
    pix_valid    = 1'b0;
    pix          = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    burst        = 1'b0;
    hold_request = 1'b0;
    pixels_sent  = 0;
    frames_sent  = 0;
    settings_used = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // A few requests under the reset settings; none completes a pixel.
    send_pixel(8'h00, 1'b0);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'h5A, 1'b1);

    // Four by two frame of extremes with a pad inside it and samples after its end.
    set_frame(9'd4, 9'd2, 8'h00, 1'b0);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'hFF, 1'b1);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'hAA, 1'b0);
    send_pixel(8'h55, 1'b0);
    send_pixel(8'hFF, 1'b1);
    send_pixel(8'h00, 1'b1);
    send_pixel(8'h3C, 1'b0);
    frames_sent++;

    // Dimensions below the minimum clamp to the smallest frame; unused index too.
    set_frame(9'd0, 9'd1, 8'hFF, 1'b1);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'h00, 1'b1);
    send_pixel(8'h00, 1'b1);
    send_pixel(8'hFF, 1'b0);
    frames_sent++;
    directed_items = pixels_sent;

    // Random settings, each followed by a few frames; some are cut short.
    phase_no = 0;
    while (pixels_sent - directed_items < RANDOM_ITEMS) begin
      burst = ($urandom_range(0, 99) < 20);
      case (phase_no)
        1: begin
          // Widest frame, with the receiver holding off so the block backs up.
          set_frame(9'd511, 9'd0, pick_border(), 1'($urandom_range(0, 1)));
          burst        = 1'b1;
          hold_request = 1'b1;
          send_frame(1'b0);
        end
        2: begin
          // Tallest frame at the narrowest width.
          set_frame(9'd2, 9'd256, pick_border(), 1'($urandom_range(0, 1)));
          send_frame(1'b0);
        end
        default: begin
          roll = $urandom_range(0, 99);
          if (roll < 10) w_raw = 9'($urandom_range(0, 1));
          else if (roll < 15) w_raw = 9'($urandom_range(13, 40));
          else w_raw = 9'($urandom_range(2, 12));
          h_raw = ($urandom_range(0, 99) < 10) ? 9'($urandom_range(0, 1))
                                               : 9'($urandom_range(2, 8));
          set_frame(w_raw, h_raw, pick_border(), ($urandom_range(0, 99) < 20));
          nfr = $urandom_range(1, 3);
          for (int f = 0; f < nfr; f++)
            send_frame((f == nfr - 1) && ($urandom_range(0, 99) < 15));
        end
      endcase
      phase_no++;
    end

    // Let the last pixels out, then keep the clock running for stray output.
    burst = 1'b0;
    settle();

    $display("Covered %0d raw requests in %0d full frames over %0d register settings,",
             pixels_sent, frames_sent, settings_used);
    $display("from clamped 2x2 frames up to 256 wide and 256 high; %0d pixels checked.",
             sb.checked);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d pixels never delivered",
               sb.mismatches, sb.expected_q.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/bde_pkg.sv
rtl/bde_front.sv
rtl/bde_queue.sv
rtl/bde_back.sv
rtl/bayer_demosaic_edge_directed.sv
sim/tb_bayer_demosaic_edge_directed.sv
